// ===== design/ppu_pkg.sv =====
package ppu_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned ACC_W       = 15;
  localparam int unsigned AVAIL_W     = 4;
  localparam int unsigned WIDTH_W     = 4;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  // One input request: a stream byte and the image restart flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_image;
  } in_t;

  // One result: an expanded pixel and its flags.
  typedef struct packed {
    logic [7:0] pixel_value;
    logic       row_end;
    logic       image_end;
    logic       last;
  } out_t;

  // Result of one extraction step handed back to the top level.
  typedef struct packed {
    out_t               result;
    logic [AVAIL_W-1:0] avail_nxt;
  } step_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BITS_PER_PIXEL = 2'd0,
    REG_IMAGE_COLUMNS  = 2'd1,
    REG_IMAGE_ROWS     = 2'd2
  } cfg_reg_t;

  // Low masks for pixel codes of one to eight bits.
  localparam logic [7:0] LOW_MASKS [8] = '{
    8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F, 8'hFF
  };

  // Range expansion of a code of the given width (1 to 8) to eight bits.
  function automatic logic [7:0] expand_code(input logic [7:0] code,
                                             input logic [WIDTH_W-1:0] width);
    logic [WIDTH_W-1:0] sh;
    logic [7:0]         m;
    begin
      sh = 4'd8 - width;
      m  = 8'd1 << sh;
      if (code == 8'd0) begin
        expand_code = 8'd0;
      end else if (code == 8'd1) begin
        expand_code = m;
      end else begin
        expand_code = (code << sh) | (m - 8'd1);
      end
    end
  endfunction

endpackage

// ===== design/packed_pixel_unpacker_unit.sv =====
// Channel   Direction  Signals                              Moves
// in_       input      in_valid, in_ready, in_data          one stream byte per request
// out_      output     out_valid, out_ready, out_data       one expanded pixel per request
// cfg_      input      cfg_wr_en, cfg_index, cfg_wdata      register write, no handshake
//
// A byte yields one pixel per cycle while out_ready does not stall, at most 8
// pixels, and holds the unpacker until its last pixel is out; a byte with no
// pixel does not hold it. The next byte is taken in the cycle the last pixel
// of the current one is registered. Reset clears the bit count, counters and
// valid flags and sets 8 bits per pixel on a 1 by 1 image. A stall on out_ready
// holds the output register and stops pixel extraction until it clears.
module packed_pixel_unpacker_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ppu_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ppu_pkg::out_t                   out_data,
  input  logic                            cfg_wr_en,
  input  logic [ppu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ppu_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [ppu_pkg::WIDTH_W-1:0] bpp_r;
  logic [ppu_pkg::COUNT_W-1:0] cols_r;
  logic [ppu_pkg::COUNT_W-1:0] rows_r;

  logic                        busy_r, busy_nxt;
  logic [ppu_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [ppu_pkg::AVAIL_W-1:0] avail_r, avail_nxt;
  logic [ppu_pkg::COUNT_W-1:0] col_r, col_nxt;
  logic [ppu_pkg::COUNT_W-1:0] row_r, row_nxt;
  logic                        done_r, done_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ppu_pkg::out_t               out_data_r, out_data_nxt;

  logic [ppu_pkg::WIDTH_W-1:0] width;
  ppu_pkg::step_t              step;
  logic                        slot_free;
  logic                        emit;
  logic                        accept;
  logic [ppu_pkg::AVAIL_W-1:0] avail_e;
  logic [2:0]                  lc;
  logic [6:0]                  lo_bits;

  // Effective pixel width: zero counts as one, above eight as eight.
  always_comb begin
    if (bpp_r == 4'd0) begin
      width = 4'd1;
    end else if (bpp_r > 4'd8) begin
      width = 4'd8;
    end else begin
      width = bpp_r;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r  <= 4'd8;
      cols_r <= 16'd1;
      rows_r <= 16'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ppu_pkg::REG_BITS_PER_PIXEL: bpp_r  <= cfg_wdata[ppu_pkg::WIDTH_W-1:0];
        ppu_pkg::REG_IMAGE_COLUMNS:  cols_r <= cfg_wdata;
        ppu_pkg::REG_IMAGE_ROWS:     rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ppu_step u_step (
    .acc          (acc_r),
    .avail        (avail_r),
    .width        (width),
    .column_count (col_r),
    .row_count    (row_r),
    .image_columns(cols_r),
    .image_rows   (rows_r),
    .step         (step)
  );

  // While a byte is held, a pixel is extracted whenever the output register is free or being drained.
  assign slot_free = !out_valid_r || out_ready;
  assign emit      = busy_r && slot_free;
  assign in_ready  = !busy_r || (emit && step.result.last);
  assign accept    = in_valid && in_ready;

  // Bit count left once this cycle's extraction is done.
  assign avail_e = emit ? step.avail_nxt : avail_r;

  // Leftover bits of the finished byte, masked to their count.
  assign lc      = avail_e[2:0];
  assign lo_bits = acc_r[6:0] & ((7'd1 << lc) - 7'd1);

  always_comb begin
    busy_nxt      = busy_r;
    acc_nxt       = acc_r;
    avail_nxt     = avail_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Pixel extraction into the output register.
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = step.result;
      avail_nxt     = step.avail_nxt;
      busy_nxt      = !step.result.last;
      if (step.result.row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 16'd1;
      end else begin
        col_nxt = col_r + 16'd1;
      end
      if (step.result.image_end) begin
        done_nxt = 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // A new request sees the state left by the extraction above.
    if (accept) begin
      if (in_data.start_image) begin
        col_nxt   = '0;
        row_nxt   = '0;
        done_nxt  = 1'b0;
        avail_nxt = '0;
      end
      if (!done_nxt && (cols_r != 16'd0) && (rows_r != 16'd0)) begin
        busy_nxt = 1'b1;
        // Leftover bits are dropped on restart or when they already fill a pixel.
        if (in_data.start_image || (avail_e >= width)) begin
          acc_nxt   = {7'd0, in_data.data_byte};
          avail_nxt = 4'd8;
        end else begin
          acc_nxt   = {lo_bits, in_data.data_byte};
          avail_nxt = {1'b0, lc} + 4'd8;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      avail_r     <= '0;
      col_r       <= '0;
      row_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      avail_r     <= avail_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/ppu_step.sv =====
module ppu_step (
  input  logic [ppu_pkg::ACC_W-1:0]   acc,
  input  logic [ppu_pkg::AVAIL_W-1:0] avail,
  input  logic [ppu_pkg::WIDTH_W-1:0] width,
  input  logic [ppu_pkg::COUNT_W-1:0] column_count,
  input  logic [ppu_pkg::COUNT_W-1:0] row_count,
  input  logic [ppu_pkg::COUNT_W-1:0] image_columns,
  input  logic [ppu_pkg::COUNT_W-1:0] image_rows,
  output ppu_pkg::step_t              step
);

  logic [ppu_pkg::AVAIL_W-1:0] shift;
  logic [ppu_pkg::ACC_W-1:0]   shifted;
  logic [7:0]                  code;
  logic [ppu_pkg::COUNT_W:0]   col_inc;
  logic [ppu_pkg::COUNT_W:0]   row_inc;
  logic                        row_end;
  logic                        img_end;

  // Take the next code from the top of the unused bits.
  assign shift   = avail - width;
  assign shifted = acc >> shift;
  assign code    = shifted[7:0] & ppu_pkg::LOW_MASKS[3'(width - 4'd1)];

  // Row and image end use at-least compares so that a size change mid-image still ends it.
  assign col_inc = {1'b0, column_count} + 17'd1;
  assign row_inc = {1'b0, row_count} + 17'd1;
  assign row_end = col_inc >= {1'b0, image_columns};
  assign img_end = row_end && (row_inc >= {1'b0, image_rows});

  // The byte is finished when too few bits remain or the image is complete.
  always_comb begin
    step.result.pixel_value = ppu_pkg::expand_code(code, width);
    step.result.row_end     = row_end;
    step.result.image_end   = img_end;
    step.result.last        = img_end || (shift < width);
    step.avail_nxt          = img_end ? '0 : shift;
  end

endmodule
